[rtl/core/wpem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wpem_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int POWER_W    = 32;
	localparam int ENERGY_W   = 48;
	localparam int CYCLE_W    = 16;
	localparam int WINDOW_DEF = 64;

	localparam logic [CYCLE_W-1:0] CYCLE_SAMPLES_RST = CYCLE_W'(64);

	// Product on its way from the multiplier into the window.
	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic                     clear_energy;
	} prod_stage_t;

	// Window average on its way into the energy accumulator.
	typedef struct packed {
		logic signed [POWER_W-1:0] avg;
		logic                      clear_energy;
	} avg_stage_t;

endpackage

`default_nettype wire

[rtl/core/wpem_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wpem_in_if import wpem_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] current_sample;
	logic signed [SAMPLE_W-1:0] voltage_sample;
	logic                       clear_energy;

	modport source (output valid, output current_sample, output voltage_sample,
		output clear_energy, input ready);
	modport sink (input valid, input current_sample, input voltage_sample,
		input clear_energy, output ready);
endinterface

interface wpem_out_if import wpem_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [POWER_W-1:0]  average_power;
	logic signed [ENERGY_W-1:0] energy_total;
	logic                       cycle_end;

	modport source (output valid, output average_power, output energy_total,
		output cycle_end, input ready);
	modport sink (input valid, input average_power, input energy_total,
		input cycle_end, output ready);
endinterface

`default_nettype wire

[rtl/core/windowed_power_energy_meter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Payload
// sample    in   valid / ready    current_sample, voltage_sample, clear_energy
// result    out  valid / ready    average_power, energy_total, cycle_end
// cfg       in   cfg_we           cfg_wdata -> cycle_samples
//
// One request is taken per cycle while the result side is not stalled; each result passes
// from the input register at acceptance through the multiplier register, the window sum
// register and the output register.
// Every stage holds its item while the stage ahead is full and stalled; empty
// stages still fill, so bubbles close up under back pressure.
// Reset needs no clearing pass: ring slots not yet written read as zero until
// the write pointer has wrapped once.

module windowed_power_energy_meter import wpem_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CYCLE_W-1:0] cfg_wdata,
	wpem_in_if.sink            sample,
	wpem_out_if.source         result
);

	logic        prod_valid;
	logic        prod_ready;
	prod_stage_t prod_data;
	logic        avg_valid;
	logic        avg_ready;
	avg_stage_t  avg_data;

	wpem_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod_data  (prod_data)
	);

	wpem_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod_data  (prod_data),
		.avg_valid  (avg_valid),
		.avg_ready  (avg_ready),
		.avg_data   (avg_data)
	);

	wpem_energy u_energy (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.avg_valid (avg_valid),
		.avg_ready (avg_ready),
		.avg_data  (avg_data),
		.result    (result)
	);

endmodule

`default_nettype wire

[rtl/core/wpem_mult.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpem_mult import wpem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wpem_in_if.sink     sample,
	output logic        prod_valid,
	input  logic        prod_ready,
	output prod_stage_t prod_data
);

	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] cur_s1;
	logic signed [SAMPLE_W-1:0] vol_s1;
	logic                       clr_s1;
	logic                       v_s2;
	logic                       adv_s1;
	logic                       adv_s2;

	assign adv_s2       = !v_s2 || prod_ready;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;
	assign prod_valid   = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= sample.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			cur_s1 <= sample.current_sample;
			vol_s1 <= sample.voltage_sample;
			clr_s1 <= sample.clear_energy;
		end
		if (adv_s2 && v_s1) begin
			prod_data.prod         <= cur_s1 * vol_s1;
			prod_data.clear_energy <= clr_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/wpem_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpem_window import wpem_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        prod_valid,
	output logic        prod_ready,
	input  prod_stage_t prod_data,
	output logic        avg_valid,
	input  logic        avg_ready,
	output avg_stage_t  avg_data
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = PROD_W + PTR_W;
	// Floor of log2(WINDOW), so a window that is not a power of two still works.
	localparam int SHIFT = $clog2(WINDOW + 1) - 1;

	logic signed [PROD_W-1:0] ring [WINDOW];
	logic signed [PROD_W-1:0] rd_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [PTR_W-1:0]         ptr_nx;
	logic                     wrapped_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  sum_nx;
	logic signed [PROD_W-1:0] old_prod;
	logic                     v_s3;
	logic                     take;
	logic                     at_end;

	assign prod_ready = !v_s3 || avg_ready;
	assign take       = prod_valid && prod_ready;
	assign avg_valid  = v_s3;
	assign at_end     = (ptr_q == PTR_W'(WINDOW - 1));

	// Until the pointer has wrapped once, the slot being replaced was never
	// written and stands for a zero product.
	assign old_prod = wrapped_q ? rd_q : '0;
	assign sum_nx   = sum_q + SUM_W'(prod_data.prod) - SUM_W'(old_prod);

	always_comb begin
		ptr_nx = ptr_q;
		if (take) begin
			ptr_nx = at_end ? '0 : ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (prod_ready) begin
				v_s3 <= prod_valid;
			end
			ptr_q <= ptr_nx;
			if (take) begin
				sum_q <= sum_nx;
				if (at_end) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// The read runs one step ahead: it fetches the slot the next product will
	// replace, which is never the slot written in the same cycle.
	always_ff @(posedge clk) begin
		if (take) begin
			ring[ptr_q] <= prod_data.prod;
		end
		rd_q <= ring[ptr_nx];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			avg_data.avg          <= POWER_W'(sum_nx >>> SHIFT);
			avg_data.clear_energy <= prod_data.clear_energy;
		end
	end

endmodule

`default_nettype wire

[rtl/core/wpem_energy.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpem_energy import wpem_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CYCLE_W-1:0] cfg_wdata,
	input  logic               avg_valid,
	output logic               avg_ready,
	input  avg_stage_t         avg_data,
	wpem_out_if.source         result
);

	localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	logic [CYCLE_W-1:0]         cycle_samples_q;
	logic [CYCLE_W-1:0]         cnt_q;
	logic [CYCLE_W-1:0]         cnt_inc;
	logic signed [ENERGY_W-1:0] acc_q;
	logic signed [ENERGY_W-1:0] acc_base;
	logic signed [ENERGY_W:0]   acc_sum;
	logic signed [ENERGY_W-1:0] acc_nx;
	logic                       cyc_end;
	logic                       v_q;
	logic                       take;

	assign avg_ready    = !v_q || result.ready;
	assign take         = avg_valid && avg_ready;
	assign result.valid = v_q;

	always_comb begin
		cnt_inc  = (avg_data.clear_energy ? '0 : cnt_q) + CYCLE_W'(1);
		cyc_end  = (cnt_inc == cycle_samples_q);
		acc_base = avg_data.clear_energy ? '0 : acc_q;
		acc_sum  = (ENERGY_W + 1)'(acc_base) + (ENERGY_W + 1)'(avg_data.avg);
		acc_nx   = acc_base;
		if (cyc_end) begin
			// Overflow shows as the two top bits of the widened sum disagreeing.
			if (acc_sum[ENERGY_W] != acc_sum[ENERGY_W-1]) begin
				acc_nx = acc_sum[ENERGY_W] ? E_MIN : E_MAX;
			end else begin
				acc_nx = acc_sum[ENERGY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_samples_q <= CYCLE_SAMPLES_RST;
			cnt_q           <= '0;
			acc_q           <= '0;
			v_q             <= 1'b0;
		end else begin
			if (cfg_we) begin
				cycle_samples_q <= cfg_wdata;
			end
			if (avg_ready) begin
				v_q <= avg_valid;
			end
			if (take) begin
				cnt_q <= cyc_end ? '0 : cnt_inc;
				acc_q <= acc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result.average_power <= avg_data.avg;
			result.energy_total  <= acc_nx;
			result.cycle_end     <= cyc_end;
		end
	end

endmodule

`default_nettype wire
